// ===== src/ctb_pkg.sv =====
// ============================================================================
// ctb_pkg
// Shared types and constants for the cursor text buffer: command and status
// codes, the cell operation code and the control bundle sent to each stack.
// ============================================================================
package ctb_pkg;

    // Default text capacity in characters
    localparam int CAPACITY_DEF = 256;

    // Fixed field widths of the stream payloads
    localparam int CHAR_W    = 8;
    localparam int CMD_W     = 3;
    localparam int POS_W     = 9;
    localparam int COUNT_W   = 9;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    // Editing commands
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT    = 3'd0,
        CMD_DELETE    = 3'd1,
        CMD_BACKSPACE = 3'd2,
        CMD_MOVE      = 3'd3,
        CMD_REPLACE   = 3'd4
    } cmd_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_RANGE = 2'd2,
        STS_FULL  = 2'd3
    } status_t;

    // Per-cycle operation applied to every cell of a stack
    typedef enum logic [1:0] {
        OP_HOLD    = 2'd0,
        OP_PUSH    = 2'd1,
        OP_POP     = 2'd2,
        OP_REPLACE = 2'd3
    } cell_op_t;

    // Control bundle from the sequencer to one stack
    typedef struct packed {
        cell_op_t            op;
        logic [CHAR_W-1:0]   push_char;
        logic [CHAR_W-1:0]   find_char;
        logic [CHAR_W-1:0]   repl_char;
    } stack_ctrl_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_MOVE   = 2'd1,
        ST_FINISH = 2'd2
    } state_t;

endpackage

// ===== src/cursor_text_buffer.sv =====
// ============================================================================
// cursor_text_buffer
// Text buffer with an edit cursor, built from two stacks of character cells.
// ============================================================================
// Usage:
//   Commands enter on the s_axis channel (tuser = command; tdata = character,
//   find character, target position). Each transaction yields exactly one
//   result on m_axis: status, both side lengths and the characters on each
//   side of the cursor.
//   Insert, delete, backspace and find-and-replace are applied to all cells
//   at once. The sequencer then enters its finish state, which loads the
//   result into the output register once that register is free, and
//   returns to idle, where the next command is taken. A cursor move walks
//   one character across the cursor per cycle in the move state until the
//   target position is reached, then finishes the same way.
//   Only one command is in work at a time; s_axis_tready is high when the
//   sequencer is idle. A result waiting in the output register does not
//   block acceptance of the next command, but that command cannot finish
//   until m_axis_tready takes the waiting result.
//   Reset empties the text (both lengths zero) and clears m_axis_tvalid; no
//   clearing pass is needed since cells beyond each length are never read.
// ============================================================================
module cursor_text_buffer
#(
    parameter int CAPACITY = ctb_pkg::CAPACITY_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // command stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] char_value, [15:8] find_char, [24:16] target_position, rest zero
    input  logic [ctb_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // [2:0] command
    input  logic [ctb_pkg::CMD_W-1:0]         s_axis_tuser,
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [1:0] status, [10:2] before_count, [19:11] after_count,
    // [27:20] before_char, [35:28] after_char, rest zero
    output logic [ctb_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

    ctb_pkg::stack_ctrl_t               left_ctrl;
    ctb_pkg::stack_ctrl_t               right_ctrl;
    logic [ctb_pkg::CHAR_W-1:0]         left_top;
    logic [ctb_pkg::CHAR_W-1:0]         right_top;
    logic [ctb_pkg::STATUS_W-1:0]       res_status;
    logic [ctb_pkg::COUNT_W-1:0]        res_before_count;
    logic [ctb_pkg::COUNT_W-1:0]        res_after_count;
    logic [ctb_pkg::CHAR_W-1:0]         res_before_char;
    logic [ctb_pkg::CHAR_W-1:0]         res_after_char;

    // Command sequencer
    ctb_ctrl
    #(
        .CAPACITY (CAPACITY)
    )
    u_ctrl
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_axis_tvalid),
        .in_ready         (s_axis_tready),
        .in_cmd           (s_axis_tuser),
        .in_char          (s_axis_tdata[7:0]),
        .in_find          (s_axis_tdata[15:8]),
        .in_target        (s_axis_tdata[24:16]),
        .left_top         (left_top),
        .right_top        (right_top),
        .left_ctrl        (left_ctrl),
        .right_ctrl       (right_ctrl),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_status       (res_status),
        .out_before_count (res_before_count),
        .out_after_count  (res_after_count),
        .out_before_char  (res_before_char),
        .out_after_char   (res_after_char)
    );

    // Text before the cursor, top = character just before it
    ctb_stack
    #(
        .DEPTH (CAPACITY)
    )
    u_left
    (
        .clk      (clk),
        .ctrl     (left_ctrl),
        .top_char (left_top)
    );

    // Text after the cursor, top = character just after it
    ctb_stack
    #(
        .DEPTH (CAPACITY)
    )
    u_right
    (
        .clk      (clk),
        .ctrl     (right_ctrl),
        .top_char (right_top)
    );

    // Result packing
    assign m_axis_tdata = {4'b0000, res_after_char, res_before_char,
                           res_after_count, res_before_count, res_status};

endmodule

// ===== src/ctb_cell.sv =====
// ============================================================================
// ctb_cell
// One character slot of a stack. Takes its upper neighbor on a push, its
// lower neighbor on a pop, or rewrites itself on a find-and-replace match.
// ============================================================================
module ctb_cell
(
    input  logic                          clk,
    input  ctb_pkg::stack_ctrl_t          ctrl,
    input  logic [ctb_pkg::CHAR_W-1:0]    prev_char,
    input  logic [ctb_pkg::CHAR_W-1:0]    next_char,
    output logic [ctb_pkg::CHAR_W-1:0]    value
);

    logic [ctb_pkg::CHAR_W-1:0] char_reg;
    logic [ctb_pkg::CHAR_W-1:0] char_next;

    // Select the new cell contents
    always_comb
    begin
        char_next = char_reg;
        case (ctrl.op)
            ctb_pkg::OP_HOLD:    char_next = char_reg;
            ctb_pkg::OP_PUSH:    char_next = prev_char;
            ctb_pkg::OP_POP:     char_next = next_char;
            ctb_pkg::OP_REPLACE:
            begin
                if (char_reg == ctrl.find_char)
                    char_next = ctrl.repl_char;
            end
            default:             char_next = char_reg;
        endcase
    end

    // Character storage, payload only
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    assign value = char_reg;

endmodule

// ===== src/ctb_stack.sv =====
// ============================================================================
// ctb_stack
// A row of cells forming one side of the cursor. Cell 0 is the top of the
// stack, i.e. the character adjacent to the cursor.
// ============================================================================
module ctb_stack
#(
    parameter int DEPTH = ctb_pkg::CAPACITY_DEF
)
(
    input  logic                          clk,
    input  ctb_pkg::stack_ctrl_t          ctrl,
    output logic [ctb_pkg::CHAR_W-1:0]    top_char
);

    logic [ctb_pkg::CHAR_W-1:0] cell_q [DEPTH];

    // Chain of cells wired to their neighbors; the top takes push_char, the bottom zero
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [ctb_pkg::CHAR_W-1:0] prev_c;
        logic [ctb_pkg::CHAR_W-1:0] next_c;

        if (i == 0)
        begin : g_top
            assign prev_c = ctrl.push_char;
        end
        else
        begin : g_mid_prev
            assign prev_c = cell_q[i-1];
        end

        if (i == DEPTH-1)
        begin : g_bottom
            assign next_c = '0;
        end
        else
        begin : g_mid_next
            assign next_c = cell_q[i+1];
        end

        ctb_cell u_cell
        (
            .clk       (clk),
            .ctrl      (ctrl),
            .prev_char (prev_c),
            .next_char (next_c),
            .value     (cell_q[i])
        );
    end

    assign top_char = cell_q[0];

endmodule

// ===== src/ctb_ctrl.sv =====
// ============================================================================
// ctb_ctrl
// Command sequencer: keeps the side lengths, drives both stacks, walks the
// cursor one character per cycle on a move and holds the result register.
// ============================================================================
module ctb_ctrl
#(
    parameter int CAPACITY = ctb_pkg::CAPACITY_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // command side
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ctb_pkg::CMD_W-1:0]       in_cmd,
    input  logic [ctb_pkg::CHAR_W-1:0]      in_char,
    input  logic [ctb_pkg::CHAR_W-1:0]      in_find,
    input  logic [ctb_pkg::POS_W-1:0]       in_target,
    // stack tops and stack control
    input  logic [ctb_pkg::CHAR_W-1:0]      left_top,
    input  logic [ctb_pkg::CHAR_W-1:0]      right_top,
    output ctb_pkg::stack_ctrl_t            left_ctrl,
    output ctb_pkg::stack_ctrl_t            right_ctrl,
    // result side
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ctb_pkg::STATUS_W-1:0]    out_status,
    output logic [ctb_pkg::COUNT_W-1:0]     out_before_count,
    output logic [ctb_pkg::COUNT_W-1:0]     out_after_count,
    output logic [ctb_pkg::CHAR_W-1:0]      out_before_char,
    output logic [ctb_pkg::CHAR_W-1:0]      out_after_char
);

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int XW  = ((CW > ctb_pkg::POS_W) ? CW : ctb_pkg::POS_W) + 1;
    localparam int OCW = ctb_pkg::COUNT_W;

    ctb_pkg::state_t                state_reg, state_next;
    logic [CW-1:0]                  left_cnt_reg, left_cnt_next;
    logic [CW-1:0]                  right_cnt_reg, right_cnt_next;
    logic [CW-1:0]                  target_reg, target_next;
    logic [ctb_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic                           out_valid_reg, out_valid_next;
    logic [ctb_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [OCW-1:0]                 res_before_cnt_reg, res_before_cnt_next;
    logic [OCW-1:0]                 res_after_cnt_reg, res_after_cnt_next;
    logic [ctb_pkg::CHAR_W-1:0]     res_before_char_reg, res_before_char_next;
    logic [ctb_pkg::CHAR_W-1:0]     res_after_char_reg, res_after_char_next;

    logic [CW:0]                    total_len;
    logic                           buf_full;
    logic                           too_far;
    logic                           out_free;
    logic                           accept;

    // Shared decode
    assign total_len = {1'b0, left_cnt_reg} + {1'b0, right_cnt_reg};
    assign buf_full  = (total_len == (CW+1)'(CAPACITY));
    assign too_far   = (XW'(in_target) > XW'(total_len));
    assign out_free  = !out_valid_reg || out_ready;
    assign accept    = in_valid && (state_reg == ctb_pkg::ST_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ctb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if ((ctb_pkg::cmd_t'(in_cmd) == ctb_pkg::CMD_MOVE) && !too_far)
                        state_next = ctb_pkg::ST_MOVE;
                    else
                        state_next = ctb_pkg::ST_FINISH;
                end
            end
            ctb_pkg::ST_MOVE:
            begin
                if (left_cnt_reg == target_reg)
                    state_next = ctb_pkg::ST_FINISH;
            end
            ctb_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = ctb_pkg::ST_IDLE;
            end
            default: state_next = ctb_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath updates
    always_comb
    begin
        in_ready             = (state_reg == ctb_pkg::ST_IDLE);
        left_cnt_next        = left_cnt_reg;
        right_cnt_next       = right_cnt_reg;
        target_next          = target_reg;
        status_next          = status_reg;
        out_valid_next       = out_valid_reg && !out_ready;
        res_status_next      = res_status_reg;
        res_before_cnt_next  = res_before_cnt_reg;
        res_after_cnt_next   = res_after_cnt_reg;
        res_before_char_next = res_before_char_reg;
        res_after_char_next  = res_after_char_reg;

        left_ctrl.op         = ctb_pkg::OP_HOLD;
        left_ctrl.push_char  = (state_reg == ctb_pkg::ST_MOVE) ? right_top : in_char;
        left_ctrl.find_char  = in_find;
        left_ctrl.repl_char  = in_char;
        right_ctrl.op        = ctb_pkg::OP_HOLD;
        right_ctrl.push_char = left_top;
        right_ctrl.find_char = in_find;
        right_ctrl.repl_char = in_char;

        case (state_reg)
            ctb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = ctb_pkg::STS_OK;
                    case (ctb_pkg::cmd_t'(in_cmd))
                        ctb_pkg::CMD_INSERT:
                        begin
                            if (buf_full)
                                status_next = ctb_pkg::STS_FULL;
                            else
                            begin
                                left_ctrl.op  = ctb_pkg::OP_PUSH;
                                left_cnt_next = left_cnt_reg + CW'(1);
                            end
                        end
                        ctb_pkg::CMD_DELETE:
                        begin
                            if (right_cnt_reg == '0)
                                status_next = ctb_pkg::STS_EMPTY;
                            else
                            begin
                                right_ctrl.op  = ctb_pkg::OP_POP;
                                right_cnt_next = right_cnt_reg - CW'(1);
                            end
                        end
                        ctb_pkg::CMD_BACKSPACE:
                        begin
                            if (left_cnt_reg == '0)
                                status_next = ctb_pkg::STS_EMPTY;
                            else
                            begin
                                left_ctrl.op  = ctb_pkg::OP_POP;
                                left_cnt_next = left_cnt_reg - CW'(1);
                            end
                        end
                        ctb_pkg::CMD_MOVE:
                        begin
                            if (too_far)
                                status_next = ctb_pkg::STS_RANGE;
                            else
                                target_next = CW'(in_target);
                        end
                        ctb_pkg::CMD_REPLACE:
                        begin
                            left_ctrl.op  = ctb_pkg::OP_REPLACE;
                            right_ctrl.op = ctb_pkg::OP_REPLACE;
                        end
                        default: status_next = ctb_pkg::STS_OK;
                    endcase
                end
            end
            ctb_pkg::ST_MOVE:
            begin
                // one character crosses the cursor per cycle
                if (left_cnt_reg > target_reg)
                begin
                    left_ctrl.op   = ctb_pkg::OP_POP;
                    right_ctrl.op  = ctb_pkg::OP_PUSH;
                    left_cnt_next  = left_cnt_reg - CW'(1);
                    right_cnt_next = right_cnt_reg + CW'(1);
                end
                else if (left_cnt_reg < target_reg)
                begin
                    right_ctrl.op  = ctb_pkg::OP_POP;
                    left_ctrl.op   = ctb_pkg::OP_PUSH;
                    right_cnt_next = right_cnt_reg - CW'(1);
                    left_cnt_next  = left_cnt_reg + CW'(1);
                end
            end
            ctb_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    res_status_next      = status_reg;
                    res_before_cnt_next  = OCW'(left_cnt_reg);
                    res_after_cnt_next   = OCW'(right_cnt_reg);
                    res_before_char_next = (left_cnt_reg != '0) ? left_top : '0;
                    res_after_char_next  = (right_cnt_reg != '0) ? right_top : '0;
                end
            end
            default: in_ready = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ctb_pkg::ST_IDLE;
            left_cnt_reg  <= '0;
            right_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            left_cnt_reg  <= left_cnt_next;
            right_cnt_reg <= right_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        target_reg          <= target_next;
        status_reg          <= status_next;
        res_status_reg      <= res_status_next;
        res_before_cnt_reg  <= res_before_cnt_next;
        res_after_cnt_reg   <= res_after_cnt_next;
        res_before_char_reg <= res_before_char_next;
        res_after_char_reg  <= res_after_char_next;
    end

    assign out_valid        = out_valid_reg;
    assign out_status       = res_status_reg;
    assign out_before_count = res_before_cnt_reg;
    assign out_after_count  = res_after_cnt_reg;
    assign out_before_char  = res_before_char_reg;
    assign out_after_char   = res_after_char_reg;

endmodule
